>>> design/rgb_colour_class_mask_assert.svh
// Assertion macros for the rgb_colour_class_mask checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef RGB_COLOUR_CLASS_MASK_ASSERT_SVH
`define RGB_COLOUR_CLASS_MASK_ASSERT_SVH

// same-cycle implication, reset-qualified
`define RGBCC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rgbcc assertion failed");

// next-cycle implication, reset-qualified
`define RGBCC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rgbcc assertion failed");

`endif

>>> design/rgbcc_pkg.sv
// Package for rgb_colour_class_mask: fixed-point weights, widths,
// register indexes and the configuration struct. No dependencies.
package rgbcc_pkg;

	localparam int unsigned LATENCY = 4;

	// BT.601 weights as 0.16 fractions
	localparam logic [15:0] WR  = 16'd19595;
	localparam logic [15:0] WG  = 16'd38470;
	localparam logic [15:0] WB  = 16'd7471;
	localparam logic [15:0] KCR = 16'd46727;
	localparam logic [15:0] KCB = 16'd36962;

	// 128 scaled by 2^32
	localparam logic signed [43:0] CHROMA_OFS = 44'sh0_80_0000_0000;

	typedef enum logic [2:0] {
		REG_MODE,
		REG_Y_BOUNDS,
		REG_CR_BOUNDS,
		REG_CB_BOUNDS,
		REG_GREEN_RED_MIN,
		REG_GREEN_RED_MAX,
		REG_BLUE_RED_MIN,
		REG_BLUE_RED_MAX
	} cfg_reg_t;

	typedef struct packed {
		logic        mode;
		logic [15:0] y_bounds;
		logic [15:0] cr_bounds;
		logic [15:0] cb_bounds;
		logic [15:0] green_red_min;
		logic [15:0] green_red_max;
		logic [15:0] blue_red_min;
		logic [15:0] blue_red_max;
	} cfg_t;

	// chroma word scaled by 2^32 -> byte, clamped
	function automatic logic [7:0] chroma_sat(input logic signed [43:0] v);
		logic [7:0] res;
		if (v[43]) begin
			res = 8'd0;
		end else if (|v[42:40]) begin
			res = 8'd255;
		end else begin
			res = v[39:32];
		end
		return res;
	endfunction

	function automatic logic in_window(input logic [7:0] v, input logic [15:0] bounds);
		return (v >= bounds[7:0]) && (v <= bounds[15:8]);
	endfunction

endpackage

>>> design/rgbcc_cfg_regs.sv
// Configuration register file for rgb_colour_class_mask.
// Depends on rgbcc_pkg (cfg_t, register indexes).
module rgbcc_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [2:0]        wr_index,
	input  logic [15:0]       wr_data,
	output rgbcc_pkg::cfg_t   cfg
);

	rgbcc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode          <= 1'b0;
			cfg_q.y_bounds      <= 16'hFF00;
			cfg_q.cr_bounds     <= 16'hFF00;
			cfg_q.cb_bounds     <= 16'hFF00;
			cfg_q.green_red_min <= 16'h0000;
			cfg_q.green_red_max <= 16'hFFFF;
			cfg_q.blue_red_min  <= 16'h0000;
			cfg_q.blue_red_max  <= 16'hFFFF;
		end else if (wr_en) begin
			case (rgbcc_pkg::cfg_reg_t'(wr_index))
				rgbcc_pkg::REG_MODE:          cfg_q.mode          <= wr_data[0];
				rgbcc_pkg::REG_Y_BOUNDS:      cfg_q.y_bounds      <= wr_data;
				rgbcc_pkg::REG_CR_BOUNDS:     cfg_q.cr_bounds     <= wr_data;
				rgbcc_pkg::REG_CB_BOUNDS:     cfg_q.cb_bounds     <= wr_data;
				rgbcc_pkg::REG_GREEN_RED_MIN: cfg_q.green_red_min <= wr_data;
				rgbcc_pkg::REG_GREEN_RED_MAX: cfg_q.green_red_max <= wr_data;
				rgbcc_pkg::REG_BLUE_RED_MIN:  cfg_q.blue_red_min  <= wr_data;
				rgbcc_pkg::REG_BLUE_RED_MAX:  cfg_q.blue_red_max  <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> design/rgbcc_class_pipe.sv
// Four-stage classification pipeline: products; luma sum, chroma differences,
// ratio compares; chroma scaling; clamp, bounds test, mode select. Depends on rgbcc_pkg.
module rgbcc_class_pipe (
	input  logic              clk,
	input  logic              arst_n,
	input  rgbcc_pkg::cfg_t   cfg,
	input  logic              in_valid,
	input  logic [7:0]        red,
	input  logic [7:0]        green,
	input  logic [7:0]        blue,
	output logic              out_valid,
	output logic              out_hit
);

	// valid bits
	logic v_s1, v_s2, v_s3, v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1: weight and ratio products
	logic [23:0] yr_s1, yg_s1, yb_s1;
	logic [23:0] grmin_s1, grmax_s1, brmin_s1, brmax_s1;
	logic [7:0]  r_s1, g_s1, b_s1;

	always_ff @(posedge clk) begin
		yr_s1    <= {8'd0, rgbcc_pkg::WR} * {16'd0, red};
		yg_s1    <= {8'd0, rgbcc_pkg::WG} * {16'd0, green};
		yb_s1    <= {8'd0, rgbcc_pkg::WB} * {16'd0, blue};
		grmin_s1 <= {8'd0, cfg.green_red_min} * {16'd0, red};
		grmax_s1 <= {8'd0, cfg.green_red_max} * {16'd0, red};
		brmin_s1 <= {8'd0, cfg.blue_red_min} * {16'd0, red};
		brmax_s1 <= {8'd0, cfg.blue_red_max} * {16'd0, red};
		r_s1     <= red;
		g_s1     <= green;
		b_s1     <= blue;
	end

	// stage 2: luma sum, chroma differences, ratio compares
	logic [23:0]        yf;
	logic [23:0]        g8, b8;
	logic [7:0]         y_s2;
	logic signed [24:0] dr_s2, db_s2;
	logic               ratio_s2;

	assign yf = yr_s1 + yg_s1 + yb_s1;
	assign g8 = {8'd0, g_s1, 8'd0};
	assign b8 = {8'd0, b_s1, 8'd0};

	always_ff @(posedge clk) begin
		y_s2     <= yf[23:16];
		dr_s2    <= $signed({1'b0, r_s1, 16'd0}) - $signed({1'b0, yf});
		db_s2    <= $signed({1'b0, b_s1, 16'd0}) - $signed({1'b0, yf});
		ratio_s2 <= (g8 > grmin_s1) && (g8 < grmax_s1) &&
			(b8 > brmin_s1) && (b8 < brmax_s1);
	end

	// stage 3: chroma scaling
	logic signed [16:0] kcr_s, kcb_s;
	logic signed [41:0] pcr_s3, pcb_s3;
	logic [7:0]         y_s3;
	logic               ratio_s3;

	assign kcr_s = $signed({1'b0, rgbcc_pkg::KCR});
	assign kcb_s = $signed({1'b0, rgbcc_pkg::KCB});

	always_ff @(posedge clk) begin
		pcr_s3   <= dr_s2 * kcr_s;
		pcb_s3   <= db_s2 * kcb_s;
		y_s3     <= y_s2;
		ratio_s3 <= ratio_s2;
	end

	// stage 4: offset, clamp, bounds test, mode select
	logic signed [43:0] vcr, vcb;
	logic [7:0]         cr, cb;
	logic               box_hit;
	logic               hit_s4;

	assign vcr = $signed({{2{pcr_s3[41]}}, pcr_s3}) + rgbcc_pkg::CHROMA_OFS;
	assign vcb = $signed({{2{pcb_s3[41]}}, pcb_s3}) + rgbcc_pkg::CHROMA_OFS;
	assign cr  = rgbcc_pkg::chroma_sat(vcr);
	assign cb  = rgbcc_pkg::chroma_sat(vcb);
	assign box_hit = rgbcc_pkg::in_window(y_s3, cfg.y_bounds) &&
		rgbcc_pkg::in_window(cr, cfg.cr_bounds) &&
		rgbcc_pkg::in_window(cb, cfg.cb_bounds);

	always_ff @(posedge clk) begin
		hit_s4 <= cfg.mode ? ratio_s3 : box_hit;
	end

	assign out_valid = v_s4;
	assign out_hit   = v_s4 & hit_s4;

endmodule

>>> design/rgb_colour_class_mask.sv
// Top level of rgb_colour_class_mask: config registers plus classification pipeline.
// Depends on rgbcc_pkg, rgbcc_cfg_regs and rgbcc_class_pipe.
//
// One pixel is taken on every clock where start is high; busy is always low.
// Each pixel gives its class bit on in_class once it has passed the pipeline,
// marked by done for exactly one cycle. The receiver cannot stall: results
// stream out in order at the input rate. The pipeline has four stages (weight
// products, luma sum and chroma differences, chroma scaling multiply, clamp
// and bounds compare). The user writes registers through wr_en/wr_index/
// wr_data only while no pixel is in flight; the block does not enforce this.
module rgb_colour_class_mask (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output logic        done,
	output logic        in_class,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [15:0] wr_data
);

	rgbcc_pkg::cfg_t cfg;
	logic            accept;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	rgbcc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	rgbcc_class_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (accept),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.out_valid (done),
		.out_hit   (in_class)
	);

endmodule

>>> design/rgbcc_checker.sv
// Port-level checker for rgb_colour_class_mask, bound to the top level.
// Depends on rgbcc_pkg and rgb_colour_class_mask_assert.svh.
`include "rgb_colour_class_mask_assert.svh"

module rgbcc_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic in_class
);

	// each accepted transaction yields exactly one result, fixed latency
	`RGBCC_ASSERT_IMP(a_latency, $past(arst_n, 4) && $past(arst_n, 3) && $past(arst_n, 2) && $past(arst_n, 1), done == $past(start && !busy, rgbcc_pkg::LATENCY))

	`RGBCC_ASSERT_IMP(a_class_needs_done, in_class, done)

	`RGBCC_ASSERT_NXT(a_never_busy, 1'b1, !busy)

endmodule

bind rgb_colour_class_mask rgbcc_checker u_rgbcc_checker (.*);
